### src/set_assoc_cache_tag_controller_macros.svh
// assertion macros shared by the tag controller modules
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH

// same-cycle implication
`define SACTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sactc check failed");

// next-cycle implication
`define SACTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sactc check failed");

`endif

### src/sactc_pkg.sv
package sactc_pkg;

    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 32;
    localparam int ADDR_W      = 32;
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int SET_W       = $clog2(SETS);
    localparam int WAY_W       = $clog2(WAYS);
    localparam int TAG_W       = ADDR_W - OFF_W - SET_W;
    localparam int ORD_W       = WAYS * WAY_W;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam logic [15:0] LFSR_SEED = 16'h0001;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    localparam logic [2:0] FUNC_READ   = 3'd0;
    localparam logic [2:0] FUNC_WRITE  = 3'd1;
    localparam logic [2:0] FUNC_PROBE  = 3'd2;
    localparam logic [2:0] FUNC_FLUSH  = 3'd3;
    localparam logic [2:0] FUNC_SFLUSH = 3'd4;

    localparam logic [1:0] POL_LRU  = 2'd0;
    localparam logic [1:0] POL_FIFO = 2'd1;
    localparam logic [1:0] POL_RAND = 2'd2;

    typedef enum logic [2:0] {
        OP_READ, OP_WRITE, OP_PROBE, OP_FLUSH, OP_SFLUSH, OP_NOP
    } t_op;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SFL} t_bstate;

    typedef struct packed {
        t_op              op;
        logic [SET_W-1:0] set;
        logic [TAG_W-1:0] tag;
    } t_item;

    typedef struct packed {
        logic              hit;
        logic              replaced;
        logic [ADDR_W-1:0] victim_address;
        logic              writeback;
        logic              fill;
        logic [ADDR_W-1:0] fill_address;
        logic              last;
    } t_rsp;

    typedef logic [WAYS-1:0][WAY_W-1:0] t_order;

    function automatic t_order ord_reset();
        t_order r;
        for (int i = 0; i < WAYS; i++) begin
            r[i] = WAY_W'(WAYS - 1 - i);
        end
        return r;
    endfunction

    function automatic t_order move_head(t_order ord, logic [WAY_W-1:0] w);
        t_order r;
        logic   seen;
        seen = 1'b0;
        r    = ord;
        r[0] = w;
        for (int i = 1; i < WAYS; i++) begin
            seen = seen | (ord[i-1] == w);
            r[i] = seen ? ord[i] : ord[i-1];
        end
        return r;
    endfunction

    function automatic t_order move_tail(t_order ord, logic [WAY_W-1:0] w);
        t_order r;
        logic   seen;
        seen = 1'b0;
        r    = ord;
        for (int i = 0; i < WAYS - 1; i++) begin
            seen = seen | (ord[i] == w);
            r[i] = seen ? ord[i+1] : ord[i];
        end
        r[WAYS-1] = w;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] blk_addr(logic [TAG_W-1:0] tag,
                                                   logic [SET_W-1:0] set);
        return {tag, set, {OFF_W{1'b0}}};
    endfunction

endpackage

### src/sactc_req_if.sv
interface sactc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] address;
    modport source (output valid, output func, output address, input ready);
    modport sink (input valid, input func, input address, output ready);
endinterface

### src/sactc_rsp_if.sv
interface sactc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        replaced;
    logic [31:0] victim_address;
    logic        writeback;
    logic        fill;
    logic [31:0] fill_address;
    logic        last;
    modport source (output valid, output hit, output replaced, output victim_address,
                    output writeback, output fill, output fill_address, output last,
                    input ready);
    modport sink (input valid, input hit, input replaced, input victim_address,
                  input writeback, input fill, input fill_address, input last,
                  output ready);
endinterface

### src/sactc_cfg_if.sv
interface sactc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/sactc_ram.sv
module sactc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/sactc_front.sv
`include "set_assoc_cache_tag_controller_macros.svh"

module sactc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sactc_req_if.sink          i_req,
    output logic               o_qv,
    output sactc_pkg::t_item   o_item,
    input  logic               i_pop
);
    sactc_pkg::t_item                  r_q [sactc_pkg::Q_DEPTH];
    logic [sactc_pkg::Q_PTR_W-1:0]     r_rd, r_wr;
    logic [sactc_pkg::Q_CNT_W-1:0]     r_cnt;
    sactc_pkg::t_item                  dec;
    logic                              push;

    // classify the request
    always_comb begin
        dec.set = i_req.address[sactc_pkg::OFF_W +: sactc_pkg::SET_W];
        dec.tag = i_req.address[sactc_pkg::OFF_W + sactc_pkg::SET_W +: sactc_pkg::TAG_W];
        unique case (i_req.func)
            sactc_pkg::FUNC_READ:   dec.op = sactc_pkg::OP_READ;
            sactc_pkg::FUNC_WRITE:  dec.op = sactc_pkg::OP_WRITE;
            sactc_pkg::FUNC_PROBE:  dec.op = sactc_pkg::OP_PROBE;
            sactc_pkg::FUNC_FLUSH:  dec.op = sactc_pkg::OP_FLUSH;
            sactc_pkg::FUNC_SFLUSH: dec.op = sactc_pkg::OP_SFLUSH;
            default:                dec.op = sactc_pkg::OP_NOP;
        endcase
    end

    assign i_req.ready = (r_cnt != sactc_pkg::Q_CNT_W'(sactc_pkg::Q_DEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign o_qv        = (r_cnt != '0);
    assign o_item      = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `SACTC_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, i_pop, r_cnt != '0)
endmodule

### src/sactc_back.sv
`include "set_assoc_cache_tag_controller_macros.svh"

module sactc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sactc_cfg_if.sink        i_cfg,
    input  logic             i_qv,
    input  sactc_pkg::t_item i_item,
    output logic             o_pop,
    sactc_rsp_if.source      o_rsp
);
    localparam int WAYS  = sactc_pkg::WAYS;
    localparam int SETS  = sactc_pkg::SETS;
    localparam int WAY_W = sactc_pkg::WAY_W;
    localparam int TAG_W = sactc_pkg::TAG_W;
    localparam int SET_W = sactc_pkg::SET_W;

    sactc_pkg::t_bstate              r_state, n_state;
    sactc_pkg::t_item                r_cur, n_cur;
    logic [1:0]                      r_policy;
    logic [15:0]                     r_lfsr, n_lfsr;
    logic [SETS-1:0][WAYS-1:0]       r_valid, n_valid, r_dirty, n_dirty;
    logic [SETS-1:0]                 r_ordw, n_ordw;
    logic                            r_ov, n_ov;
    sactc_pkg::t_rsp                 r_rsp, n_rsp;
    sactc_pkg::t_order               r_sord, n_sord;
    logic [WAYS-1:0][TAG_W-1:0]      r_stag, n_stag;
    logic [WAYS-1:0]                 r_dmask, n_dmask;
    logic [WAY_W-1:0]                r_pos, n_pos;

    logic [SET_W-1:0]                rd_set;
    logic [WAYS-1:0][TAG_W-1:0]      w_tag;
    logic [WAYS-1:0]                 tag_we;
    logic [sactc_pkg::ORD_W-1:0]     ord_raw, ord_wdata;
    logic                            ord_we;
    sactc_pkg::t_order               ord;
    logic [WAYS-1:0]                 hv;
    logic                            hit, out_free, later;
    logic [WAY_W-1:0]                hw, vw;
    logic [15:0]                     lfsr_step;

    // one tag memory per way, all read at the same set
    for (genvar g = 0; g < WAYS; g++) begin : g_tag
        sactc_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_tag (
            .i_clk  (i_clk),
            .i_we   (tag_we[g]),
            .i_waddr(r_cur.set),
            .i_wdata(r_cur.tag),
            .i_raddr(rd_set),
            .o_rdata(w_tag[g])
        );
    end

    sactc_ram #(.WIDTH(sactc_pkg::ORD_W), .DEPTH(SETS)) u_ord (
        .i_clk  (i_clk),
        .i_we   (ord_we),
        .i_waddr(r_cur.set),
        .i_wdata(ord_wdata),
        .i_raddr(rd_set),
        .o_rdata(ord_raw)
    );

    assign rd_set = (r_state == sactc_pkg::S_IDLE) ? i_item.set : r_cur.set;
    assign ord    = r_ordw[r_cur.set] ? sactc_pkg::t_order'(ord_raw) : sactc_pkg::ord_reset();

    always_comb begin
        hv = '0;
        hw = '0;
        for (int w = 0; w < WAYS; w++) begin
            hv[w] = r_valid[r_cur.set][w] && (w_tag[w] == r_cur.tag);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hv[w]) begin
                hw = WAY_W'(w);
            end
        end
        hit       = |hv;
        vw        = (r_policy == sactc_pkg::POL_RAND) ? r_lfsr[WAY_W-1:0] : ord[WAYS-1];
        lfsr_step = (r_lfsr >> 1) ^ (r_lfsr[0] ? sactc_pkg::LFSR_MASK : 16'h0000);
        later     = 1'b0;
        for (int i = 0; i < WAYS; i++) begin
            if (WAY_W'(i) > r_pos) begin
                later = later | r_dmask[i];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_lfsr    = r_lfsr;
        n_valid   = r_valid;
        n_dirty   = r_dirty;
        n_ordw    = r_ordw;
        n_ov      = r_ov;
        n_rsp     = r_rsp;
        n_sord    = r_sord;
        n_stag    = r_stag;
        n_dmask   = r_dmask;
        n_pos     = r_pos;
        o_pop     = 1'b0;
        tag_we    = '0;
        ord_we    = 1'b0;
        ord_wdata = ord;
        out_free  = !r_ov || o_rsp.ready;
        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            sactc_pkg::S_IDLE: begin
                if (i_qv) begin
                    o_pop   = 1'b1;
                    n_cur   = i_item;
                    n_state = sactc_pkg::S_LOOK;
                end
            end
            sactc_pkg::S_LOOK: begin
                if (out_free) begin
                    n_rsp      = '0;
                    n_rsp.last = 1'b1;
                    n_ov       = 1'b1;
                    n_state    = sactc_pkg::S_IDLE;
                    case (r_cur.op) inside
                        sactc_pkg::OP_READ, sactc_pkg::OP_WRITE: begin
                            if (hit) begin
                                n_rsp.hit = 1'b1;
                                if (r_cur.op == sactc_pkg::OP_WRITE) begin
                                    n_dirty[r_cur.set][hw] = 1'b1;
                                end
                                if (r_policy != sactc_pkg::POL_FIFO &&
                                    r_policy != sactc_pkg::POL_RAND) begin
                                    ord_we    = 1'b1;
                                    ord_wdata = sactc_pkg::move_head(ord, hw);
                                    n_ordw[r_cur.set] = 1'b1;
                                end
                            end else begin
                                if (r_policy == sactc_pkg::POL_RAND) begin
                                    n_lfsr = lfsr_step;
                                end else begin
                                    ord_we    = 1'b1;
                                    ord_wdata = sactc_pkg::move_head(ord, vw);
                                    n_ordw[r_cur.set] = 1'b1;
                                end
                                n_rsp.replaced  = r_valid[r_cur.set][vw];
                                n_rsp.writeback = r_valid[r_cur.set][vw] &&
                                                  r_dirty[r_cur.set][vw];
                                if (r_valid[r_cur.set][vw]) begin
                                    n_rsp.victim_address =
                                        sactc_pkg::blk_addr(w_tag[vw], r_cur.set);
                                end
                                n_rsp.fill         = 1'b1;
                                n_rsp.fill_address =
                                    sactc_pkg::blk_addr(r_cur.tag, r_cur.set);
                                tag_we[vw]             = 1'b1;
                                n_valid[r_cur.set][vw] = 1'b1;
                                n_dirty[r_cur.set][vw] = (r_cur.op == sactc_pkg::OP_WRITE);
                            end
                        end
                        sactc_pkg::OP_PROBE: begin
                            n_rsp.hit = hit;
                        end
                        sactc_pkg::OP_FLUSH: begin
                            if (hit) begin
                                n_rsp.hit            = 1'b1;
                                n_rsp.victim_address =
                                    sactc_pkg::blk_addr(w_tag[hw], r_cur.set);
                                n_rsp.writeback        = r_dirty[r_cur.set][hw];
                                n_valid[r_cur.set][hw] = 1'b0;
                                n_dirty[r_cur.set][hw] = 1'b0;
                                ord_we    = 1'b1;
                                ord_wdata = sactc_pkg::move_tail(ord, hw);
                                n_ordw[r_cur.set] = 1'b1;
                            end
                        end
                        sactc_pkg::OP_SFLUSH: begin
                            // dirty mask by order position, head first
                            for (int i = 0; i < WAYS; i++) begin
                                n_dmask[i] = r_valid[r_cur.set][ord[i]] &&
                                             r_dirty[r_cur.set][ord[i]];
                            end
                            n_sord             = ord;
                            n_stag             = w_tag;
                            n_pos              = '0;
                            n_valid[r_cur.set] = '0;
                            n_dirty[r_cur.set] = '0;
                            if (n_dmask != '0) begin
                                n_ov    = r_ov && !o_rsp.ready;
                                n_rsp   = r_rsp;
                                n_state = sactc_pkg::S_SFL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sactc_pkg::S_SFL: begin
                if (r_dmask[r_pos]) begin
                    if (out_free) begin
                        n_rsp                = '0;
                        n_rsp.victim_address =
                            sactc_pkg::blk_addr(r_stag[r_sord[r_pos]], r_cur.set);
                        n_rsp.writeback      = 1'b1;
                        n_rsp.last           = !later;
                        n_ov                 = 1'b1;
                        if (later) begin
                            n_pos = r_pos + 1'b1;
                        end else begin
                            n_state = sactc_pkg::S_IDLE;
                        end
                    end
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = sactc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sactc_pkg::S_IDLE;
            r_policy <= sactc_pkg::POL_LRU;
            r_lfsr   <= sactc_pkg::LFSR_SEED;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_ordw   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lfsr  <= n_lfsr;
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_ordw  <= n_ordw;
            r_ov    <= n_ov;
            if (i_cfg.valid) begin
                r_policy <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_rsp   <= n_rsp;
        r_sord  <= n_sord;
        r_stag  <= n_stag;
        r_dmask <= n_dmask;
        r_pos   <= n_pos;
    end

    assign i_cfg.ready          = 1'b1;
    assign o_rsp.valid          = r_ov;
    assign o_rsp.hit            = r_rsp.hit;
    assign o_rsp.replaced       = r_rsp.replaced;
    assign o_rsp.victim_address = r_rsp.victim_address;
    assign o_rsp.writeback      = r_rsp.writeback;
    assign o_rsp.fill           = r_rsp.fill;
    assign o_rsp.fill_address   = r_rsp.fill_address;
    assign o_rsp.last           = r_rsp.last;

    `SACTC_ASSERT_IMP(a_nonlast_in_sfl, i_clk, i_rst_n, r_ov && !r_rsp.last, r_state == sactc_pkg::S_SFL)
    `SACTC_ASSERT_IMP(a_lfsr_live, i_clk, i_rst_n, 1'b1, r_lfsr != 16'h0000)
endmodule

### src/set_assoc_cache_tag_controller.sv
// tag controller of a 4-way, 64-set write-back cache with 32-byte blocks
// i_req: one request per handshake, func (read, write, probe, flush block,
//   flush set) and a byte address
// o_rsp: result items; every request gives one, a set flush gives one per
//   dirty way (one if none), and last marks the final result of a request
// i_cfg: replacement policy write (lru, fifo, random); ready is always high,
//   write it only while no request is in flight
// path: an accepted request is popped from the queue with the tag memory read,
//   then its result is registered; the back end finishes one request before it
//   pops the next, as the tag and order memories are read through a register
// after its lookup, a set flush steps through the order positions up to the last dirty way
// a 2-entry queue decouples the request side from the lookup engine, so
//   requests keep being taken while a result waits in the output register
// receiver stall: the output register holds its result and the engine waits,
//   then the queue fills and i_req.ready drops
// reset: valid, dirty and order-written bits clear at once, the policy
//   returns to lru and the lfsr to its seed; no clearing pass is needed
module set_assoc_cache_tag_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sactc_req_if.sink   i_req,
    sactc_cfg_if.sink   i_cfg,
    sactc_rsp_if.source o_rsp
);
    // front-to-back queue head
    logic             q_valid;
    logic             q_pop;
    sactc_pkg::t_item q_item;

    // accept and classify requests
    sactc_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .o_qv   (q_valid),
        .o_item (q_item),
        .i_pop  (q_pop)
    );

    // tag lookup, replacement and result generation
    sactc_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (i_cfg),
        .i_qv   (q_valid),
        .i_item (q_item),
        .o_pop  (q_pop),
        .o_rsp  (o_rsp)
    );
endmodule
